// ===== hw/rtl/etcb_pkg.sv =====
// ----------------------------------------------------------------------------
// etcb_pkg
// Types, constants and tables shared by the placement transform and binner.
// ----------------------------------------------------------------------------
package etcb_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

   localparam int ROT_W = 34;

   localparam logic signed [ROT_W-1:0] PI_Q28      = 34'sd843314857;
   localparam logic signed [ROT_W-1:0] TWO_PI_Q28  = 34'sd1686629713;
   localparam logic signed [ROT_W-1:0] HALF_PI_Q28 = 34'sd421657428;
   localparam logic signed [ROT_W-1:0] GAIN_Q30    = 34'sd652032874;

   typedef enum logic [2:0] {
      CSR_MIN_X = 3'd0,
      CSR_MIN_Y = 3'd1,
      CSR_MAX_X = 3'd2,
      CSR_MAX_Y = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic        [15:0] scale_factor;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
      logic signed [11:0] cell_x;
      logic signed [11:0] cell_y;
      logic               in_region;
   } rsp_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ROT_W-1:0] t;
      logic                    flip;
   } rot_type;

   typedef struct packed {
      logic [2:0][36:0] loc;
      logic [2:0][31:0] origin;
   } side_type;

   function automatic logic signed [ROT_W-1:0] atan_q28(input logic [4:0] idx);
      logic signed [ROT_W-1:0] r;
      case (idx)
         5'd0:    r = 34'sd210828714;
         5'd1:    r = 34'sd124459457;
         5'd2:    r = 34'sd65760959;
         5'd3:    r = 34'sd33381290;
         5'd4:    r = 34'sd16755422;
         5'd5:    r = 34'sd8385879;
         5'd6:    r = 34'sd4193963;
         5'd7:    r = 34'sd2097109;
         5'd8:    r = 34'sd1048571;
         5'd9:    r = 34'sd524287;
         5'd10:   r = 34'sd262144;
         5'd11:   r = 34'sd131072;
         5'd12:   r = 34'sd65536;
         5'd13:   r = 34'sd32768;
         5'd14:   r = 34'sd16384;
         5'd15:   r = 34'sd8192;
         5'd16:   r = 34'sd4096;
         5'd17:   r = 34'sd2048;
         5'd18:   r = 34'sd1024;
         5'd19:   r = 34'sd512;
         5'd20:   r = 34'sd256;
         5'd21:   r = 34'sd128;
         5'd22:   r = 34'sd64;
         5'd23:   r = 34'sd32;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/euler_transform_cell_binner.sv =====
// ----------------------------------------------------------------------------
// euler_transform_cell_binner
// Rotates and scales a part offset into world space and bins it into cells.
// ----------------------------------------------------------------------------
// Accepts one item per clock (busy never rises); each result appears on
// rsp_data for one cycle with rsp_valid, once the item has passed the CORDIC
// rotation chain and the matrix multiply stages.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module euler_transform_cell_binner (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  etcb_pkg::req_type req_data,
   output logic              rsp_valid,
   output etcb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [11:0]       csr_wdata
);

   localparam int N  = etcb_pkg::NSTEPS;
   localparam int SL = N + 6;

   logic signed [11:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   logic [N+8:0] vld_ff;

   logic signed [2:0][etcb_pkg::ROT_W-1:0] red_in, red_ff;
   logic [2:0][48:0] mul_ff;
   logic [2:0][31:0] org_ff;
   logic signed [15:0] ang [3];
   logic signed [31:0] ofs [3];

   etcb_pkg::rot_type rot_w [3][N+1];
   etcb_pkg::rot_type rot0_ff [3];
   etcb_pkg::rot_type fold_in [3];
   etcb_pkg::side_type side_ff [SL];

   logic signed [31:0] sn_ff [3];
   logic signed [31:0] cs_ff [3];
   logic signed [31:0] ncy_ff, nsx_ff;

   logic signed [33:0] sxsy_ff, cxsy_ff, m00_ff, m01_ff, m12_ff, m22_ff;
   logic signed [33:0] szcx_ff, cxcz_ff, sxsz_ff, sxcz_ff;
   logic signed [31:0] c1_sz_ff, c1_cz_ff, c1_sy_ff;
   logic signed [33:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [33:0] c2_m00_ff, c2_m01_ff, c2_m12_ff, c2_m22_ff;
   logic signed [33:0] c2_szcx_ff, c2_cxcz_ff, c2_sxsz_ff, c2_sxcz_ff;
   logic signed [31:0] c2_sy_ff;
   logic signed [2:0][2:0][34:0] mat_ff;
   logic signed [2:0][2:0][65:0] prd_ff;
   logic signed [2:0][44:0] sum_ff;
   etcb_pkg::rsp_type rsp_in, rsp_ff;

   function automatic logic signed [33:0] fmul30(input logic signed [33:0] a,
                                                 input logic signed [31:0] b);
      logic signed [65:0] p;
      p = a * b;
      return p[63:30];
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= -12'sd2048;
         min_y_ff <= -12'sd2048;
         max_x_ff <= 12'sd2047;
         max_y_ff <= 12'sd2047;
      end else if (csr_valid) begin
         case (etcb_pkg::csr_index_type'(csr_index))
            etcb_pkg::CSR_MIN_X: min_x_ff <= csr_wdata;
            etcb_pkg::CSR_MIN_Y: min_y_ff <= csr_wdata;
            etcb_pkg::CSR_MAX_X: max_x_ff <= csr_wdata;
            etcb_pkg::CSR_MAX_Y: max_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[N+7:0], start};
      end
   end

   assign ang[0] = req_data.angle_x;
   assign ang[1] = req_data.angle_y;
   assign ang[2] = req_data.angle_z;
   assign ofs[0] = req_data.offset_x;
   assign ofs[1] = req_data.offset_y;
   assign ofs[2] = req_data.offset_z;

   always_comb begin
      logic signed [16:0] na;
      logic signed [etcb_pkg::ROT_W-1:0] t0;
      for (int a = 0; a < 3; a++) begin
         na = -($signed({ang[a][15], ang[a]}));
         t0 = $signed({na[16], na, 16'h0000});
         if (t0 > etcb_pkg::PI_Q28) begin
            red_in[a] = t0 - etcb_pkg::TWO_PI_Q28;
         end else if (t0 < -etcb_pkg::PI_Q28) begin
            red_in[a] = t0 + etcb_pkg::TWO_PI_Q28;
         end else begin
            red_in[a] = t0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         red_ff[a] <= red_in[a];
         mul_ff[a] <= 49'(ofs[a] * $signed({1'b0, req_data.scale_factor}));
      end
      org_ff[0] <= req_data.origin_x;
      org_ff[1] <= req_data.origin_y;
      org_ff[2] <= req_data.origin_z;
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         fold_in[a].x    = etcb_pkg::GAIN_Q30;
         fold_in[a].y    = '0;
         fold_in[a].flip = 1'b0;
         fold_in[a].t    = red_ff[a];
         if ($signed(red_ff[a]) > etcb_pkg::HALF_PI_Q28) begin
            fold_in[a].t    = etcb_pkg::PI_Q28 - red_ff[a];
            fold_in[a].flip = 1'b1;
         end else if ($signed(red_ff[a]) < -etcb_pkg::HALF_PI_Q28) begin
            fold_in[a].t    = -etcb_pkg::PI_Q28 - red_ff[a];
            fold_in[a].flip = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         rot0_ff[a] <= fold_in[a];
         side_ff[0].loc[a] <= mul_ff[a][48:12];
      end
      side_ff[0].origin <= org_ff;
      for (int s = 1; s < SL; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      assign rot_w[a][0] = rot0_ff[a];
      for (genvar s = 0; s < N; s++) begin : g_step
         etcb_cordic_stage u_stage (
            .clock    (clock),
            .step_idx (5'(s)),
            .rot_i    (rot_w[a][s]),
            .rot_o    (rot_w[a][s+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      logic signed [etcb_pkg::ROT_W-1:0] c;
      for (int a = 0; a < 3; a++) begin
         c = rot_w[a][N].flip ? -rot_w[a][N].x : rot_w[a][N].x;
         cs_ff[a] <= c[31:0];
         sn_ff[a] <= rot_w[a][N].y[31:0];
      end
      c = -rot_w[1][N].x;
      ncy_ff <= rot_w[1][N].flip ? rot_w[1][N].x[31:0] : c[31:0];
      c = -rot_w[0][N].y;
      nsx_ff <= c[31:0];
   end

   always_ff @(posedge clock) begin
      sxsy_ff  <= fmul30(34'(sn_ff[0]), sn_ff[1]);
      cxsy_ff  <= fmul30(34'(cs_ff[0]), sn_ff[1]);
      m00_ff   <= fmul30(34'(cs_ff[1]), cs_ff[2]);
      m01_ff   <= fmul30(34'(ncy_ff), sn_ff[2]);
      m12_ff   <= fmul30(34'(nsx_ff), cs_ff[1]);
      m22_ff   <= fmul30(34'(cs_ff[0]), cs_ff[1]);
      szcx_ff  <= fmul30(34'(sn_ff[2]), cs_ff[0]);
      cxcz_ff  <= fmul30(34'(cs_ff[0]), cs_ff[2]);
      sxsz_ff  <= fmul30(34'(sn_ff[0]), sn_ff[2]);
      sxcz_ff  <= fmul30(34'(sn_ff[0]), cs_ff[2]);
      c1_sz_ff <= sn_ff[2];
      c1_cz_ff <= cs_ff[2];
      c1_sy_ff <= sn_ff[1];
   end

   always_ff @(posedge clock) begin
      pa_ff      <= fmul30(sxsy_ff, c1_cz_ff);
      pb_ff      <= fmul30(sxsy_ff, c1_sz_ff);
      pc_ff      <= fmul30(cxsy_ff, c1_cz_ff);
      pd_ff      <= fmul30(cxsy_ff, c1_sz_ff);
      c2_m00_ff  <= m00_ff;
      c2_m01_ff  <= m01_ff;
      c2_m12_ff  <= m12_ff;
      c2_m22_ff  <= m22_ff;
      c2_szcx_ff <= szcx_ff;
      c2_cxcz_ff <= cxcz_ff;
      c2_sxsz_ff <= sxsz_ff;
      c2_sxcz_ff <= sxcz_ff;
      c2_sy_ff   <= c1_sy_ff;
   end

   always_ff @(posedge clock) begin
      mat_ff[0][0] <= 35'(c2_m00_ff);
      mat_ff[0][1] <= 35'(c2_m01_ff);
      mat_ff[0][2] <= 35'(c2_sy_ff);
      mat_ff[1][0] <= 35'(pa_ff) + 35'(c2_szcx_ff);
      mat_ff[1][1] <= 35'(c2_cxcz_ff) - 35'(pb_ff);
      mat_ff[1][2] <= 35'(c2_m12_ff);
      mat_ff[2][0] <= 35'(c2_sxsz_ff) - 35'(pc_ff);
      mat_ff[2][1] <= 35'(pd_ff) + 35'(c2_sxcz_ff);
      mat_ff[2][2] <= 35'(c2_m22_ff);
   end

   always_ff @(posedge clock) begin
      logic signed [28:0] mr;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            mr = $signed(mat_ff[r][k][34:6]);
            prd_ff[r][k] <= 66'(mr * $signed(side_ff[N+4].loc[k]));
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [67:0] acc;
      for (int r = 0; r < 3; r++) begin
         acc = 68'($signed(prd_ff[r][0])) + 68'($signed(prd_ff[r][1]))
             + 68'($signed(prd_ff[r][2]));
         sum_ff[r] <= 45'($signed(acc[67:24])) + 45'($signed(side_ff[N+5].origin[r]));
      end
   end

   always_comb begin
      logic signed [31:0] w [3];
      for (int r = 0; r < 3; r++) begin
         if ($signed(sum_ff[r]) > 45'sd2147483647) begin
            w[r] = 32'sh7FFFFFFF;
         end else if ($signed(sum_ff[r]) < -45'sd2147483648) begin
            w[r] = 32'sh80000000;
         end else begin
            w[r] = sum_ff[r][31:0];
         end
      end
      rsp_in.world_x   = w[0];
      rsp_in.world_y   = w[1];
      rsp_in.world_z   = w[2];
      rsp_in.cell_x    = w[0][31:20];
      rsp_in.cell_y    = w[1][31:20];
      rsp_in.in_region = ($signed(w[0][31:20]) >= min_x_ff)
                      && ($signed(w[0][31:20]) <= max_x_ff)
                      && ($signed(w[1][31:20]) >= min_y_ff)
                      && ($signed(w[1][31:20]) <= max_y_ff);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[N+8];
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/etcb_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// etcb_cordic_stage
// One registered CORDIC rotation step for one angle.
// ----------------------------------------------------------------------------
module etcb_cordic_stage (
   input  logic              clock,
   input  logic [4:0]        step_idx,
   input  etcb_pkg::rot_type rot_i,
   output etcb_pkg::rot_type rot_o
);

   etcb_pkg::rot_type             rot_ff;
   etcb_pkg::rot_type             rot_in;
   logic signed [etcb_pkg::ROT_W-1:0] dx;
   logic signed [etcb_pkg::ROT_W-1:0] dy;

   always_comb begin
      dx = rot_i.y >>> step_idx;
      dy = rot_i.x >>> step_idx;
      rot_in = rot_i;
      if (!rot_i.t[etcb_pkg::ROT_W-1]) begin
         rot_in.x = rot_i.x - dx;
         rot_in.y = rot_i.y + dy;
         rot_in.t = rot_i.t - etcb_pkg::atan_q28(step_idx);
      end else begin
         rot_in.x = rot_i.x + dx;
         rot_in.y = rot_i.y - dy;
         rot_in.t = rot_i.t + etcb_pkg::atan_q28(step_idx);
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in;
   end

   assign rot_o = rot_ff;

endmodule

// ===== tb/tb_euler_transform_cell_binner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_euler_transform_cell_binner
// Sends placements through the transform and cell binner. A built-in predictor
// computes the expected world position, cell and region flag for each item.
// Results are checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_euler_transform_cell_binner;
   import etcb_pkg::*;

   localparam int LATENCY = CORDIC_STEPS + 9;
   localparam logic [2:0] CSR_BAD_INDEX = 3'd7;
   localparam logic [2:0] CSR_SPARE_INDEX = 3'd4;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [2:0]  csr_index;
   logic [11:0] csr_wdata;

   logic signed [11:0] region_lo_x, region_lo_y, region_hi_x, region_hi_y;
   rsp_type placement_q[$];
   int n_fail = 0;
   int n_items = 0;
   int n_checked = 0;
   int n_inside = 0;

   const longint arctan_tab[24] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
      4193963, 2097109, 1048571, 524287, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048,
      1024, 512, 256, 128, 64, 32};

   euler_transform_cell_binner uut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void sin_cos(input longint ang, output longint sn,
                                   output longint cs);
      longint t, x, y, dx, dy;
      bit flip;
      t = ang * 65536;
      x = longint'(GAIN_Q30);
      y = 0;
      flip = 0;
      while (t > longint'(PI_Q28)) t -= longint'(TWO_PI_Q28);
      while (t < -longint'(PI_Q28)) t += longint'(TWO_PI_Q28);
      if (t > longint'(HALF_PI_Q28)) begin
         t = longint'(PI_Q28) - t;
         flip = 1;
      end else if (t < -longint'(HALF_PI_Q28)) begin
         t = -longint'(PI_Q28) - t;
         flip = 1;
      end
      for (int i = 0; i < NSTEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (t >= 0) begin
            x -= dx;
            y += dy;
            t -= arctan_tab[i];
         end else begin
            x += dx;
            y -= dy;
            t += arctan_tab[i];
         end
      end
      cs = flip ? -x : x;
      sn = y;
   endfunction

   function automatic longint mul30(input longint a, input longint b);
      return (a * b) >>> 30;
   endfunction

   function automatic rsp_type place_and_bin(input req_type p);
      longint sx, cx, sy, cy, sz, cz, sxsy, cxsy, acc, wv, cx_cell, cy_cell;
      longint m[3][3];
      longint loc[3];
      longint org[3];
      longint w[3];
      rsp_type r;
      sin_cos(-longint'(p.angle_x), sx, cx);
      sin_cos(-longint'(p.angle_y), sy, cy);
      sin_cos(-longint'(p.angle_z), sz, cz);
      sxsy = mul30(sx, sy);
      cxsy = mul30(cx, sy);
      m[0][0] = mul30(cy, cz);
      m[0][1] = mul30(-cy, sz);
      m[0][2] = sy;
      m[1][0] = mul30(sxsy, cz) + mul30(sz, cx);
      m[1][1] = mul30(cx, cz) - mul30(sxsy, sz);
      m[1][2] = mul30(-sx, cy);
      m[2][0] = mul30(sx, sz) - mul30(cxsy, cz);
      m[2][1] = mul30(cxsy, sz) + mul30(sx, cz);
      m[2][2] = mul30(cx, cy);
      loc[0] = (longint'(p.offset_x) * longint'({1'b0, p.scale_factor})) >>> 12;
      loc[1] = (longint'(p.offset_y) * longint'({1'b0, p.scale_factor})) >>> 12;
      loc[2] = (longint'(p.offset_z) * longint'({1'b0, p.scale_factor})) >>> 12;
      org[0] = p.origin_x;
      org[1] = p.origin_y;
      org[2] = p.origin_z;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int k = 0; k < 3; k++) acc += (m[i][k] >>> 6) * loc[k];
         wv = org[i] + (acc >>> 24);
         if (wv > 64'sd2147483647) wv = 64'sd2147483647;
         if (wv < -64'sd2147483648) wv = -64'sd2147483648;
         w[i] = wv;
      end
      cx_cell = w[0] >>> 20;
      cy_cell = w[1] >>> 20;
      r.world_x = w[0][31:0];
      r.world_y = w[1][31:0];
      r.world_z = w[2][31:0];
      r.cell_x = cx_cell[11:0];
      r.cell_y = cy_cell[11:0];
      r.in_region = cx_cell >= region_lo_x && cx_cell <= region_hi_x &&
                    cy_cell >= region_lo_y && cy_cell <= region_hi_y;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (placement_q.size() == 0) begin
            $error("result with no item outstanding");
            n_fail++;
         end else begin
            exp_r = placement_q.pop_front();
            n_checked++;
            if (exp_r.in_region) n_inside++;
            if (rsp_data.world_x !== exp_r.world_x) begin
               $error("world_x expected %0d got %0d", exp_r.world_x, rsp_data.world_x);
               n_fail++;
            end
            if (rsp_data.world_y !== exp_r.world_y) begin
               $error("world_y expected %0d got %0d", exp_r.world_y, rsp_data.world_y);
               n_fail++;
            end
            if (rsp_data.world_z !== exp_r.world_z) begin
               $error("world_z expected %0d got %0d", exp_r.world_z, rsp_data.world_z);
               n_fail++;
            end
            if (rsp_data.cell_x !== exp_r.cell_x) begin
               $error("cell_x expected %0d got %0d", exp_r.cell_x, rsp_data.cell_x);
               n_fail++;
            end
            if (rsp_data.cell_y !== exp_r.cell_y) begin
               $error("cell_y expected %0d got %0d", exp_r.cell_y, rsp_data.cell_y);
               n_fail++;
            end
            if (rsp_data.in_region !== exp_r.in_region) begin
               $error("in_region expected %0b got %0b", exp_r.in_region,
                      rsp_data.in_region);
               n_fail++;
            end
         end
      end
   end

   task automatic send_item(input req_type p, input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (busy);
      placement_q.push_back(place_and_bin(p));
      n_items++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (placement_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_region(input logic [2:0] idx, input logic [11:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MIN_X: region_lo_x = val;
         CSR_MIN_Y: region_lo_y = val;
         CSR_MAX_X: region_hi_x = val;
         CSR_MAX_Y: region_hi_y = val;
         default: ;
      endcase
   endtask

   task automatic set_region(input logic [11:0] lx, input logic [11:0] ly,
                             input logic [11:0] hx, input logic [11:0] hy);
      write_region(CSR_MIN_X, lx);
      write_region(CSR_MIN_Y, ly);
      write_region(CSR_MAX_X, hx);
      write_region(CSR_MAX_Y, hy);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(3))
         0: return 32'($signed($urandom_range(2097152)) - 1048576);
         1: return 32'($signed($urandom_range(134217728)) - 67108864);
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type rand_placement();
      req_type p;
      p.angle_x = $urandom();
      p.angle_y = $urandom();
      p.angle_z = $urandom();
      p.scale_factor = ($urandom_range(3) == 0) ? 16'd4096 : 16'($urandom());
      p.offset_x = rand_pos();
      p.offset_y = rand_pos();
      p.offset_z = rand_pos();
      p.origin_x = rand_pos();
      p.origin_y = rand_pos();
      p.origin_z = rand_pos();
      return p;
   endfunction

   function automatic req_type make_placement(input logic [15:0] a,
                                              input logic [15:0] s,
                                              input logic [31:0] off,
                                              input logic [31:0] org);
      req_type p;
      p.angle_x = a;
      p.angle_y = -a;
      p.angle_z = a;
      p.scale_factor = s;
      p.offset_x = off;
      p.offset_y = -off;
      p.offset_z = off;
      p.origin_x = org;
      p.origin_y = org;
      p.origin_z = -org;
      return p;
   endfunction

   task automatic test_directed();
      logic [15:0] angles[10] = '{16'h0000, 16'h7FFF, 16'h8000, 16'd6434,
                                  -16'd6434, 16'd6435, 16'd12868, -16'd12869,
                                  16'd25736, 16'd1};
      for (int i = 0; i < 10; i++)
         send_item(make_placement(angles[i], 16'd4096, 32'h0010_0000, 32'h0), 0);
      send_item(make_placement(16'h0, 16'h0000, 32'h7FFF_FFFF, 32'h0123_4567), 0);
      send_item(make_placement(16'h0, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0);
      send_item(make_placement(16'h0, 16'hFFFF, 32'h8000_0000, 32'h8000_0000), 0);
      send_item(make_placement(16'h1234, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0);
      send_item(make_placement(16'h8000, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000), 0);
      send_item(make_placement(16'h0, 16'd4096, 32'hFFFF_FFFF, 32'h000F_FFFF), 0);
      send_item(make_placement(16'h0, 16'd4096, 32'h0000_0001, 32'hFFF0_0000), 0);
      drain();
   endtask

   task automatic test_region_settings();
      set_region(12'h000, 12'h000, 12'h000, 12'h000);
      for (int i = 0; i < 4; i++)
         send_item(make_placement(16'h0, 16'd4096, 32'h0000_0000,
                                  32'($signed(i) * 32'sh0008_0000 - 32'sh0010_0000)), 0);
      drain();
      set_region(12'h7FF, 12'h7FF, 12'h800, 12'h800);
      for (int i = 0; i < 4; i++) send_item(rand_placement(), 0);
      drain();
      write_region(CSR_BAD_INDEX, 12'hFFF);
      write_region(CSR_SPARE_INDEX, 12'h555);
      set_region(12'h800, 12'h800, 12'h7FF, 12'h7FF);
      for (int i = 0; i < 4; i++) send_item(rand_placement(), 0);
      drain();
   endtask

   task automatic test_random_phase(input int idle_pct, input int count);
      logic [11:0] a, b, c, d;
      a = $urandom();
      b = $urandom();
      c = $urandom();
      d = $urandom();
      if ($urandom_range(3) != 0) begin
         a = 12'($signed($urandom_range(1000)) - 800);
         b = 12'($signed($urandom_range(1000)) - 800);
         c = 12'($signed(a) + $signed($urandom_range(1000)));
         d = 12'($signed(b) + $signed($urandom_range(1000)));
      end
      set_region(a, b, c, d);
      for (int i = 0; i < count; i++) begin
         send_item(rand_placement(), idle_pct);
         if (i == count / 2) begin
            start <= 1'b0;
            while (placement_q.size() != 0) @(posedge clock);
         end
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      region_lo_x = -12'sd2048;
      region_lo_y = -12'sd2048;
      region_hi_x = 12'sd2047;
      region_hi_y = 12'sd2047;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_region_settings();
      for (int ph = 0; ph < 4; ph++) test_random_phase(35, 95);
      for (int ph = 0; ph < 4; ph++) test_random_phase(75, 95);
      for (int ph = 0; ph < 4; ph++) test_random_phase(0, 95);
      $display("Covered %0d placements, %0d results checked, %0d inside the region.",
               n_items, n_checked, n_inside);
      $display("Angles, scales, saturation and region settings swept, idle mixes varied.");
      if (n_fail == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/etcb_pkg.sv
hw/rtl/etcb_cordic_stage.sv
hw/rtl/euler_transform_cell_binner.sv
tb/tb_euler_transform_cell_binner.sv
